FILE: hdl/wsd_pkg.sv
package wsd_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int SCALE_W    = 10;
	localparam int SHAKE_W    = 19;
	localparam int SQ_W       = 19;
	localparam int SUM_W      = 17;
	localparam int SQSUM_W    = 25;
	localparam int WIN_W      = 7;
	localparam int PROD_W     = 32;
	localparam int VAR_W      = 31;
	localparam int SCALE_SQ_W = 20;
	localparam int RAD_W      = 52;
	localparam int ROOT_W     = 26;
	localparam int REM_W      = ROOT_W + 3;
	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int STEP_W     = 5;
	localparam int RECIP_W    = 32;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd200;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_DIFF,
		S_SCALE,
		S_ROOT,
		S_RECIP,
		S_FIX,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic acc_en;
		logic win_close;
		logic sq_en;
		logic diff_en;
		logic scl_en;
		logic root_step;
		logic recip_en;
		logic fix_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic win_last;
		logic root_last;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/window_std_deviation_top.sv
// Windowed standard deviation meter.
// The sample channel takes one signed 10-bit word per cycle when valid and
// ready are both high. Samples are summed over non-overlapping windows of
// WINDOW words; the word that closes a window yields one shake word,
// floor(scale * population standard deviation), on the shake channel.
// The shake word is computed after the edge that accepts the closing sample:
// products and differences, then the bit-per-cycle square root, then the
// divide by WINDOW, and last the load of the output register.
// Sampling continues while that math runs; only the next closing sample is
// held off until the math unit is free again, so short windows are paced by
// the square root iteration.
// The result sits in an output register; a stall on shake_ready holds it and
// the next result waits in the math unit, which then holds off the closing
// sample of the window after it.
// scale is written through cfg_we / cfg_wdata only while the block is idle;
// the user must keep to this, as the block does not enforce it. Reset clears
// the sums, the sample count and any pending result, and sets scale to 200.
module window_std_deviation_top
	import wsd_pkg::*;
#(
	parameter int WINDOW = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [SCALE_W-1:0]         cfg_wdata,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       shake_valid,
	input  logic                       shake_ready,
	output logic [SHAKE_W-1:0]         shake
);

	cmd_t cmd;
	sts_t sts;

	wsd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	wsd_dpath #(
		.WINDOW (WINDOW)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.sample      (sample),
		.shake_ready (shake_ready),
		.shake_valid (shake_valid),
		.shake       (shake),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

FILE: hdl/wsd_ctrl.sv
module wsd_ctrl
	import wsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.win_close) begin
					state_d = S_SQUARE;
				end
			end
			S_SQUARE: state_d = S_DIFF;
			S_DIFF:   state_d = S_SCALE;
			S_SCALE:  state_d = S_ROOT;
			S_ROOT: begin
				if (sts.root_last) begin
					state_d = S_RECIP;
				end
			end
			S_RECIP:  state_d = S_FIX;
			S_FIX:    state_d = S_EMIT;
			S_EMIT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Samples keep flowing while the math runs; only the word that closes a
	// window waits until the math is free to take its sums.
	always_comb begin
		sample_ready  = !(sts.win_last && (state_q != S_IDLE));
		cmd           = '0;
		cmd.acc_en    = sample_valid && sample_ready;
		cmd.win_close = cmd.acc_en && sts.win_last;
		cmd.sq_en     = (state_q == S_SQUARE);
		cmd.diff_en   = (state_q == S_DIFF);
		cmd.scl_en    = (state_q == S_SCALE);
		cmd.root_step = (state_q == S_ROOT);
		cmd.recip_en  = (state_q == S_RECIP);
		cmd.fix_en    = (state_q == S_FIX);
		cmd.out_load  = (state_q == S_EMIT) && sts.out_free;
	end

	a_close_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.win_close |-> state_q == S_IDLE)
		else $error("window closed while math busy");

	a_close_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.win_close |=> state_q == S_SQUARE)
		else $error("math did not start after window close");

	a_root_stay: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT) && !sts.root_last |=> state_q == S_ROOT)
		else $error("root iteration left early");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a pending word");

endmodule

FILE: hdl/wsd_dpath.sv
module wsd_dpath
	import wsd_pkg::*;
#(
	parameter int WINDOW = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [SCALE_W-1:0]         cfg_wdata,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       shake_ready,
	output logic                       shake_valid,
	output logic [SHAKE_W-1:0]         shake,
	input  cmd_t                       cmd,
	output sts_t                       sts
);

	localparam int CNT_W = $clog2(WINDOW);
	localparam logic [WIN_W-1:0] WIN_N = WIN_W'(WINDOW);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / WINDOW);

	logic [SCALE_W-1:0]        scale_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [SQSUM_W-1:0]        sqsum_q;
	logic signed [SUM_W-1:0]   snap_sum_q;
	logic [SQSUM_W-1:0]        snap_sqsum_q;
	logic [PROD_W-1:0]         nsq_q;
	logic [PROD_W-1:0]         sumsq_q;
	logic [VAR_W-1:0]          var_q;
	logic [SCALE_SQ_W-1:0]     scale_sq_q;
	logic [RAD_W-1:0]          rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [STEP_W-1:0]         step_q;
	logic [ROOT_W-1:0]         qest_q;
	logic [SHAKE_W-1:0]        quot_q;
	logic                      shake_valid_q;
	logic [SHAKE_W-1:0]        shake_q;

	logic signed [2*SAMPLE_W-1:0] sq_full;
	logic [SQ_W-1:0]              sq;
	logic signed [SUM_W-1:0]      sum_d;
	logic [SQSUM_W-1:0]           sqsum_d;
	logic signed [2*SUM_W-1:0]    sum_sq_full;
	logic [REM_W-1:0]             rem_shift;
	logic [REM_W-1:0]             trial;
	logic [ROOT_W+RECIP_W-1:0]    recip_prod;
	logic [ROOT_W+WIN_W-1:0]      back_prod;
	logic [ROOT_W-1:0]            resid;
	logic [ROOT_W-1:0]            quot_full;

	assign sq_full     = sample * sample;
	assign sq          = SQ_W'(sq_full);
	assign sum_d       = sum_q + SUM_W'(sample);
	assign sqsum_d     = sqsum_q + SQSUM_W'(sq);
	assign sum_sq_full = snap_sum_q * snap_sum_q;

	// One root bit per step, two radicand bits shifted in from the top.
	assign rem_shift  = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial      = REM_W'({root_q, 2'b01});

	// The reciprocal estimate is low by at most one; the residue fixes it.
	assign recip_prod = root_q * RECIP;
	assign back_prod  = qest_q * WIN_N;
	assign resid      = root_q - ROOT_W'(back_prod);
	assign quot_full  = (resid >= ROOT_W'(WIN_N)) ? qest_q + ROOT_W'(1) : qest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
		end else if (cmd.acc_en) begin
			if (cmd.win_close) begin
				cnt_q   <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
			end else begin
				cnt_q   <= cnt_q + CNT_W'(1);
				sum_q   <= sum_d;
				sqsum_q <= sqsum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.win_close) begin
			snap_sum_q   <= sum_d;
			snap_sqsum_q <= sqsum_d;
		end
		if (cmd.sq_en) begin
			nsq_q   <= PROD_W'(snap_sqsum_q * WIN_N);
			sumsq_q <= PROD_W'(sum_sq_full);
		end
		if (cmd.diff_en) begin
			var_q      <= VAR_W'(nsq_q - sumsq_q);
			scale_sq_q <= scale_q * scale_q;
		end
		if (cmd.scl_en) begin
			rad_q <= RAD_W'(var_q * scale_sq_q);
		end else if (cmd.root_step) begin
			rad_q <= rad_q << 2;
		end
		if (cmd.recip_en) begin
			qest_q <= recip_prod[ROOT_W+RECIP_W-1 -: ROOT_W];
		end
		if (cmd.fix_en) begin
			quot_q <= SHAKE_W'(quot_full);
		end
		if (cmd.out_load) begin
			shake_q <= quot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			root_q <= '0;
			step_q <= '0;
		end else if (cmd.scl_en) begin
			rem_q  <= '0;
			root_q <= '0;
			step_q <= '0;
		end else if (cmd.root_step) begin
			step_q <= step_q + STEP_W'(1);
			if (rem_shift >= trial) begin
				rem_q  <= rem_shift - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shake_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			shake_valid_q <= 1'b1;
		end else if (shake_ready) begin
			shake_valid_q <= 1'b0;
		end
	end

	assign sts.win_last  = (cnt_q == CNT_W'(WINDOW - 1));
	assign sts.root_last = (step_q == STEP_W'(ROOT_STEPS - 1));
	assign sts.out_free  = !shake_valid_q || shake_ready;

	assign shake_valid = shake_valid_q;
	assign shake       = shake_q;

endmodule
